@@ hdl/websocket_frame_deframer_core_defines.svh @@
// assertion macros for the websocket frame deframer
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define WSDF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wsdf assertion failed");
`define WSDF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wsdf assertion failed");
`else
`define WSDF_ASSERT(lbl, prop)
`define WSDF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ hdl/wsdf_pkg.sv @@
// types and constants shared by the websocket frame deframer
package wsdf_pkg;

  localparam int unsigned MAX_HEADER_BYTES = 14;
  localparam int unsigned LEN_W = 63;

  localparam logic [3:0] HDR_BASE_END = 4'd2;
  localparam logic [3:0] LEN16_END    = 4'd4;
  localparam logic [3:0] LEN64_END    = 4'(MAX_HEADER_BYTES - 4);
  localparam logic [3:0] KEY_BYTES    = 4'd4;
  localparam logic [6:0] LEN_CODE_16  = 7'd126;
  localparam logic [6:0] LEN_CODE_64  = 7'd127;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 63'd5000000;

  localparam logic [0:0] CFG_MAX_LEN  = 1'b0;
  localparam logic [0:0] CFG_REQ_MASK = 1'b1;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_KEY,
    PH_DATA,
    PH_DROP
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HDR,
    KIND_DATA,
    KIND_ERR
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_UNMASKED,
    ST_TOO_LONG,
    ST_HDR_TRUNC,
    ST_PAY_TRUNC
  } status_t;

  typedef struct packed {
    logic [LEN_W-1:0] max_len;
    logic             req_mask;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } item_t;

endpackage

@@ hdl/wsdf_in_reg.sv @@
// input register stage for received bytes
module wsdf_in_reg import wsdf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output logic       s1_valid,
  output item_t      s1_item,
  input  logic       s1_take
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready = !valid_r || s1_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (s1_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.data <= in_byte;
      item_r.eob  <= in_end;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

@@ hdl/wsdf_cfg_regs.sv @@
// configuration registers for the deframer
module wsdf_cfg_regs import wsdf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index,
  input  logic [LEN_W-1:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_LEN:  cfg_nxt.max_len  = cfg_data;
        CFG_REQ_MASK: cfg_nxt.req_mask = cfg_data[0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_len  <= MAX_LEN_RESET;
      cfg_r.req_mask <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/wsdf_parser.sv @@
// frame header parser, payload unmasking and result register
`include "websocket_frame_deframer_core_defines.svh"
module wsdf_parser import wsdf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             s1_valid,
  input  item_t            s1_item,
  output logic             s1_take,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_data,
  output logic             out_fin,
  output logic [2:0]       out_rsv,
  output logic [3:0]       out_opcode,
  output logic [LEN_W-1:0] out_length,
  output logic [2:0]       out_status,
  output logic             out_last
);

  phase_t           phase_r, phase_nxt;
  logic [3:0]       hidx_r, hidx_nxt;
  logic [7:0]       fhb_r, fhb_nxt;
  logic [6:0]       lc_r, lc_nxt;
  logic             mb_r, mb_nxt;
  logic [63:0]      pl_r, pl_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [1:0]       kidx_r, kidx_nxt;

  logic             res_valid;
  kind_t            res_kind;
  status_t          res_status;
  logic             res_last;
  logic [7:0]       res_data;
  logic             do_len;
  logic             do_hdr;
  logic             frame_done;
  logic [3:0]       ext_end;
  logic [3:0]       key_end;
  logic [7:0]       key_byte;
  logic [7:0]       b;
  logic             eob;

  logic             out_valid_r, out_valid_nxt;
  kind_t            out_kind_r;
  logic [7:0]       out_data_r;
  logic             out_fin_r;
  logic [2:0]       out_rsv_r;
  logic [3:0]       out_opcode_r;
  logic [LEN_W-1:0] out_length_r;
  status_t          out_status_r;
  logic             out_last_r;

  assign s1_take = s1_valid && (!out_valid_r || out_ready);
  assign b       = s1_item.data;
  assign eob     = s1_item.eob;

  assign ext_end    = (lc_r == LEN_CODE_16) ? LEN16_END : LEN64_END;
  assign key_end    = ((lc_r < LEN_CODE_16) ? HDR_BASE_END : ext_end) + KEY_BYTES;
  assign frame_done = s1_take && res_valid && res_last;

  always_comb begin
    unique case (kidx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    hidx_nxt   = hidx_r;
    fhb_nxt    = fhb_r;
    lc_nxt     = lc_r;
    mb_nxt     = mb_r;
    pl_nxt     = pl_r;
    key_nxt    = key_r;
    rem_nxt    = rem_r;
    kidx_nxt   = kidx_r;
    res_valid  = 1'b0;
    res_kind   = KIND_ERR;
    res_status = ST_OK;
    res_last   = 1'b0;
    res_data   = 8'd0;
    do_len     = 1'b0;
    do_hdr     = 1'b0;

    unique case (phase_r)
      PH_HDR0: begin
        fhb_nxt   = b;
        lc_nxt    = 7'd0;
        mb_nxt    = 1'b0;
        pl_nxt    = 64'd0;
        key_nxt   = 32'd0;
        kidx_nxt  = 2'd0;
        hidx_nxt  = 4'd1;
        phase_nxt = PH_HDR1;
        if (eob) begin
          res_valid  = 1'b1;
          res_status = ST_HDR_TRUNC;
          res_last   = 1'b1;
          phase_nxt  = PH_HDR0;
        end
      end
      PH_HDR1: begin
        mb_nxt   = b[7];
        lc_nxt   = b[6:0];
        hidx_nxt = HDR_BASE_END;
        if (!b[7] && cfg.req_mask) begin
          res_valid  = 1'b1;
          res_status = ST_UNMASKED;
          res_last   = 1'b1;
          phase_nxt  = eob ? PH_HDR0 : PH_DROP;
        end else if (b[6:0] < LEN_CODE_16) begin
          pl_nxt = {57'd0, b[6:0]};
          do_len = 1'b1;
        end else begin
          phase_nxt = PH_EXT;
          if (eob) begin
            res_valid  = 1'b1;
            res_status = ST_HDR_TRUNC;
            res_last   = 1'b1;
            phase_nxt  = PH_HDR0;
          end
        end
      end
      PH_EXT: begin
        pl_nxt   = {pl_r[55:0], b};
        hidx_nxt = hidx_r + 4'd1;
        if (hidx_nxt == ext_end) begin
          do_len = 1'b1;
        end else if (eob) begin
          res_valid  = 1'b1;
          res_status = ST_HDR_TRUNC;
          res_last   = 1'b1;
          phase_nxt  = PH_HDR0;
        end
      end
      PH_KEY: begin
        key_nxt  = {key_r[23:0], b};
        hidx_nxt = hidx_r + 4'd1;
        if (hidx_nxt == key_end) begin
          do_hdr = 1'b1;
        end else if (eob) begin
          res_valid  = 1'b1;
          res_status = ST_HDR_TRUNC;
          res_last   = 1'b1;
          phase_nxt  = PH_HDR0;
        end
      end
      PH_DATA: begin
        kidx_nxt  = kidx_r + 2'd1;
        rem_nxt   = rem_r - LEN_W'(1);
        res_valid = 1'b1;
        res_kind  = KIND_DATA;
        res_data  = b ^ key_byte;
        if (rem_r == {{(LEN_W-1){1'b0}}, 1'b1}) begin
          res_last  = 1'b1;
          phase_nxt = PH_HDR0;
        end else if (eob) begin
          res_status = ST_PAY_TRUNC;
          res_last   = 1'b1;
          phase_nxt  = PH_HDR0;
        end
      end
      PH_DROP: begin
        if (eob) begin
          phase_nxt = PH_HDR0;
        end
      end
      default: phase_nxt = PH_HDR0;
    endcase

    // length complete
    if (do_len) begin
      if (pl_nxt > {1'b0, cfg.max_len}) begin
        res_valid  = 1'b1;
        res_status = ST_TOO_LONG;
        res_last   = 1'b1;
        phase_nxt  = eob ? PH_HDR0 : PH_DROP;
      end else if (mb_nxt) begin
        phase_nxt = PH_KEY;
        if (eob) begin
          res_valid  = 1'b1;
          res_status = ST_HDR_TRUNC;
          res_last   = 1'b1;
          phase_nxt  = PH_HDR0;
        end
      end else begin
        do_hdr = 1'b1;
      end
    end

    // header complete
    if (do_hdr) begin
      res_valid = 1'b1;
      res_kind  = KIND_HDR;
      if (pl_nxt == 64'd0) begin
        res_last  = 1'b1;
        phase_nxt = PH_HDR0;
      end else if (eob) begin
        res_status = ST_PAY_TRUNC;
        res_last   = 1'b1;
        phase_nxt  = PH_HDR0;
      end else begin
        phase_nxt = PH_DATA;
        rem_nxt   = pl_nxt[LEN_W-1:0];
        kidx_nxt  = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      hidx_r  <= 4'd0;
      fhb_r   <= 8'd0;
      lc_r    <= 7'd0;
      mb_r    <= 1'b0;
      pl_r    <= 64'd0;
      key_r   <= 32'd0;
      rem_r   <= '0;
      kidx_r  <= 2'd0;
    end else if (s1_take) begin
      phase_r <= phase_nxt;
      hidx_r  <= hidx_nxt;
      fhb_r   <= fhb_nxt;
      lc_r    <= lc_nxt;
      mb_r    <= mb_nxt;
      pl_r    <= pl_nxt;
      key_r   <= key_nxt;
      rem_r   <= rem_nxt;
      kidx_r  <= kidx_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_take) begin
      out_valid_nxt = res_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && res_valid) begin
      out_kind_r   <= res_kind;
      out_data_r   <= res_data;
      out_status_r <= res_status;
      out_last_r   <= res_last;
      if (res_kind == KIND_DATA) begin
        out_fin_r    <= 1'b0;
        out_rsv_r    <= 3'd0;
        out_opcode_r <= 4'd0;
        out_length_r <= '0;
      end else begin
        out_fin_r    <= fhb_nxt[7];
        out_rsv_r    <= fhb_nxt[6:4];
        out_opcode_r <= fhb_nxt[3:0];
        out_length_r <= pl_nxt[LEN_W-1:0];
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_data   = out_data_r;
  assign out_fin    = out_fin_r;
  assign out_rsv    = out_rsv_r;
  assign out_opcode = out_opcode_r;
  assign out_length = out_length_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  `WSDF_ASSERT(a_data_rem_nonzero, phase_r == PH_DATA |-> rem_r != '0)
  `WSDF_ASSERT(a_ext_long_code, phase_r == PH_EXT |-> lc_r == LEN_CODE_16 || lc_r == LEN_CODE_64)
  `WSDF_ASSERT(a_last_ends_frame, frame_done |=> phase_r == PH_HDR0 || phase_r == PH_DROP)
  `WSDF_ASSERT(a_key_before_end, phase_r == PH_KEY |-> hidx_r < key_end)
  `WSDF_ASSERT_ALWAYS(a_no_take_in_reset, !rst_n |=> !out_valid_r)

endmodule

@@ hdl/websocket_frame_deframer_core.sv @@
// top level of the websocket frame deframer
// an accepted byte passes the input reg and then the result reg before its result shows
// throughput: one byte per cycle; while a result waits for out_ready one more byte
// enters the input reg, then in_ready stays low until the result leaves
// bytes that finish no header or payload step give no result
// reset (rst_n low, synchronous) empties both stages, returns the parser to the first
// header byte and loads max_payload_len 5000000 and require_mask 1
module websocket_frame_deframer_core import wsdf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_end,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_data,
  output logic             out_fin,
  output logic [2:0]       out_rsv,
  output logic [3:0]       out_opcode,
  output logic [LEN_W-1:0] out_length,
  output logic [2:0]       out_status,
  output logic             out_last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index,
  input  logic [LEN_W-1:0] cfg_data
);

  cfg_t  cfg;
  logic  s1_valid;
  item_t s1_item;
  logic  s1_take;

  wsdf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wsdf_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_end   (in_end),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_take  (s1_take)
  );

  wsdf_parser u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item),
    .s1_take    (s1_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .out_data   (out_data),
    .out_fin    (out_fin),
    .out_rsv    (out_rsv),
    .out_opcode (out_opcode),
    .out_length (out_length),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule
